/* rtl/core/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// Shared sizes, codes and types for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int VAL_W    = 32;
	localparam int POS_W    = 7;
	localparam int OP_W     = 2;
	localparam int STS_W    = 3;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND    = 2'd0,
		OP_DEL_VALUE = 2'd1,
		OP_DEL_POS   = 2'd2,
		OP_LIST      = 2'd3
	} opcode_t;

	typedef enum logic [STS_W-1:0] {
		STS_DONE  = 3'd0,
		STS_NONE  = 3'd1,
		STS_FULL  = 3'd2,
		STS_ELEM  = 3'd3,
		STS_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_FETCH,
		S_SHIFT,
		S_LIST,
		S_REPLY
	} state_t;

endpackage

/* rtl/core/ordered_list_engine_top.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of 32-bit values held in one RAM and walked by a
// small sequencer: append, delete by value, delete by position, listing.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  opcode, item_value, target_position
//  out      out_valid/ out_stall status, element_value, element_position,
//                                entry_count, last_result
//
//  Every read of the list goes through the single RAM read port, one entry
//  a cycle except while out_stall pauses a listing.
//  in_stall is high from acceptance until the sequencer returns to idle.
//  Results sit in an output register; out_stall holds it and pauses a listing.
//  Reset clears the entry count and the sequencer state; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module ordered_list_engine_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ole_pkg::OP_W-1:0]       opcode,
	input  logic signed [ole_pkg::VAL_W-1:0] item_value,
	input  logic [ole_pkg::POS_W-1:0]      target_position,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ole_pkg::STS_W-1:0]      status,
	output logic signed [ole_pkg::VAL_W-1:0] element_value,
	output logic [ole_pkg::POS_W-1:0]      element_position,
	output logic [ole_pkg::POS_W-1:0]      entry_count,
	output logic                           last_result
);

	import ole_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VAL_W-1:0]   val_q;
	status_t            rsts_q;
	logic [VAL_W-1:0]   rval_q;
	logic [CNT_W-1:0]   rpos_q;

	logic               out_valid_q;
	logic [STS_W-1:0]   status_q;
	logic [VAL_W-1:0]   value_q;
	logic [POS_W-1:0]   position_q;
	logic [POS_W-1:0]   ecount_q;
	logic               last_q;

	logic               accept;
	logic               can_push;
	logic               push;
	status_t            push_sts;
	logic [VAL_W-1:0]   push_val;
	logic [CNT_W-1:0]   push_pos;
	logic               push_last;
	opcode_t            op;
	logic               full;
	logic               pos_ok;
	logic               match;
	logic [CNT_W-1:0]   idx_inc;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;

	ole_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ole_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign op       = opcode_t'(opcode);
	assign accept   = in_valid && !in_stall;
	assign can_push = !out_valid_q || !out_stall;
	assign full     = (count_q >= CNT_W'(CAPACITY));
	assign pos_ok   = (CMP_W'(target_position) != '0) &&
	                  (CMP_W'(target_position) <= CMP_W'(count_q));
	assign match    = (ram_rdata == val_q);
	assign idx_inc  = CNT_W'(idx_q) + CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_APPEND:    state_d = S_REPLY;
						OP_DEL_VALUE: state_d = (count_q == '0) ? S_REPLY : S_SEARCH;
						OP_DEL_POS:   state_d = pos_ok ? S_FETCH : S_REPLY;
						OP_LIST:      state_d = (count_q == '0) ? S_REPLY : S_LIST;
						default:      state_d = S_IDLE;
					endcase
				end
			end
			S_SEARCH: begin
				if (match) begin
					state_d = S_SHIFT;
				end else if (idx_inc == count_q) begin
					state_d = S_REPLY;
				end
			end
			S_FETCH: state_d = S_SHIFT;
			S_SHIFT: begin
				if (idx_inc >= count_q) begin
					state_d = S_REPLY;
				end
			end
			S_LIST: begin
				if (can_push && (idx_inc == count_q)) begin
					state_d = S_IDLE;
				end
			end
			S_REPLY: begin
				if (can_push) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = IDX_W'(idx_inc);
		push      = 1'b0;
		push_sts  = rsts_q;
		push_val  = rval_q;
		push_pos  = rpos_q;
		push_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				ram_raddr = (op == OP_DEL_POS) ? IDX_W'(target_position - POS_W'(1)) : '0;
				ram_we    = accept && (op == OP_APPEND) && !full;
				ram_waddr = IDX_W'(count_q);
				ram_wdata = item_value;
			end
			S_SEARCH, S_FETCH: begin
				ram_raddr = IDX_W'(idx_inc);
			end
			S_SHIFT: begin
				// move the later entry down one place, fetch the one after it
				ram_we    = (idx_inc < count_q);
				ram_raddr = idx_q + IDX_W'(2);
			end
			S_LIST: begin
				// re-read the same entry while the output holds
				ram_raddr = can_push ? IDX_W'(idx_inc) : idx_q;
				push      = 1'b1;
				push_sts  = STS_ELEM;
				push_val  = ram_rdata;
				push_pos  = idx_inc;
				push_last = (idx_inc == count_q);
			end
			S_REPLY: begin
				push = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && (op == OP_APPEND) && !full) begin
				count_q <= count_q + CNT_W'(1);
			end else if ((state_q == S_SHIFT) && (idx_inc >= count_q)) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q  <= item_value;
					idx_q  <= '0;
					rval_q <= '0;
					rpos_q <= '0;
					unique case (op)
						OP_APPEND: begin
							if (full) begin
								rsts_q <= STS_FULL;
							end else begin
								rsts_q <= STS_DONE;
								rpos_q <= count_q + CNT_W'(1);
							end
						end
						OP_DEL_VALUE: rsts_q <= STS_NONE;
						OP_DEL_POS: begin
							if (pos_ok) begin
								rsts_q <= STS_DONE;
								rpos_q <= CNT_W'(target_position);
								idx_q  <= IDX_W'(target_position - POS_W'(1));
							end else begin
								rsts_q <= STS_NONE;
							end
						end
						OP_LIST: rsts_q <= STS_EMPTY;
						default: rsts_q <= STS_NONE;
					endcase
				end
			end
			S_SEARCH: begin
				if (match) begin
					rsts_q <= STS_DONE;
					rval_q <= ram_rdata;
					rpos_q <= idx_inc;
				end else begin
					idx_q <= IDX_W'(idx_inc);
				end
			end
			S_FETCH: rval_q <= ram_rdata;
			S_SHIFT: begin
				if (idx_inc < count_q) begin
					idx_q <= IDX_W'(idx_inc);
				end
			end
			S_LIST: begin
				if (can_push) begin
					idx_q <= IDX_W'(idx_inc);
				end
			end
			S_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_push) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push) begin
			status_q   <= push_sts;
			value_q    <= push_val;
			position_q <= POS_W'(push_pos);
			ecount_q   <= POS_W'(count_q);
			last_q     <= push_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign element_value    = value_q;
	assign element_position = position_q;
	assign entry_count      = ecount_q;
	assign last_result      = last_q;

endmodule

/* rtl/core/ole_ram.sv */
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/ole_checker.sv */
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks on the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ole_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [ole_pkg::OP_W-1:0]         opcode,
	input logic signed [ole_pkg::VAL_W-1:0] item_value,
	input logic [ole_pkg::POS_W-1:0]        target_position,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [ole_pkg::STS_W-1:0]        status,
	input logic signed [ole_pkg::VAL_W-1:0] element_value,
	input logic [ole_pkg::POS_W-1:0]        element_position,
	input logic [ole_pkg::POS_W-1:0]        entry_count,
	input logic                             last_result
);

	import ole_pkg::*;

	// an accepted beat keeps the block busy, with in_stall high in the cycle after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	// hold a stalled input beat until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid &&
		$stable({opcode, item_value, target_position}))
		else $error("stalled input beat changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable({status, element_value, element_position, entry_count, last_result}))
		else $error("stalled result beat changed");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_EMPTY) |->
		last_result && (entry_count == '0) && (element_position == '0))
		else $error("empty marker with non-empty fields");

	// only a listing gives more than one result
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STS_ELEM) |-> last_result)
		else $error("non-listing result not flagged as last");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (.*);
